>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the voice allocator RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

>>> src/mpva_pkg.sv
// ----------------------------------------------------------------------------
// mpva_pkg
// Types, constants and the oscillator base table of the voice allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpva_pkg;

  // Build-time configuration
  localparam int Voices = 3;
  localparam logic [63:0] BusClockHz = 64'd1022727;

  localparam int VoiceIdxW = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int VoiceW    = 2;
  localparam int NoteW     = 7;
  localparam int OffNoteW  = 8;
  localparam int NoteOffset = 3;
  localparam int WordW     = 16;
  localparam int ClassW    = 4;
  localparam int OctW      = 4;
  localparam int Semitones = 12;

  // n / 12 as (n * 171) >> 11, exact for n up to 130
  localparam int DivTwelveMul   = 171;
  localparam int DivTwelveShift = 11;
  localparam int ProdW          = 16;

  // Octave 13 is the reference point of the base table (no shift)
  localparam int TopOctave = 13;

  // 2^(r/12) in unsigned Q32, rounded to nearest
  localparam logic [63:0] SemitoneQ32 [Semitones] = '{
    64'd4294967296, 64'd4550359342, 64'd4820937788, 64'd5107605667,
    64'd5411319705, 64'd5733093519, 64'd6074001000, 64'd6435179895,
    64'd6817835604, 64'd7223245206, 64'd7652761717, 64'd8107818609
  };

  localparam int BaseW = $clog2(64'd440 * SemitoneQ32[11] / BusClockHz + 64'd1);

  // floor(440 * 2^(r/12) * 2^32 / bus clock); octave q then shifts right by 13 - q
  localparam logic [BaseW-1:0] FreqBase [Semitones] = '{
    BaseW'(64'd440 * SemitoneQ32[0]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[1]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[2]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[3]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[4]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[5]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[6]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[7]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[8]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[9]  / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[10] / BusClockHz),
    BaseW'(64'd440 * SemitoneQ32[11] / BusClockHz)
  };

  typedef enum logic {
    ModeNoteOff = 1'b0,
    ModeNoteOn  = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ActNoMatch = 3'd0,
    ActStarted = 3'd1,
    ActStopped = 3'd2,
    ActNoVoice = 3'd3,
    ActTooHigh = 3'd4
  } action_e;

  typedef struct packed {
    logic [OffNoteW-1:0] note_n;
    logic [ClassW-1:0]   pitch_class;
    logic [OctW-1:0]     octave;
    logic [WordW-1:0]    word;
    logic                too_high;
  } pitch_t;

  typedef struct packed {
    action_e              action;
    logic [VoiceIdxW-1:0] voice;
    logic                 out_of_voices;
  } alloc_t;

  typedef struct packed {
    action_e           action;
    logic [VoiceW-1:0] voice;
    logic [WordW-1:0]  frequency_word;
    logic [ClassW-1:0] pitch_class;
    logic [OctW-1:0]   octave;
    logic              out_of_voices;
  } result_t;

endpackage

>>> src/mpva_if.sv
// ----------------------------------------------------------------------------
// mpva_if
// Valid/ready channels for note events and allocation results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpva_evt_if;
  logic                          valid;
  logic                          ready;
  mpva_pkg::mode_e               mode;
  logic [mpva_pkg::NoteW-1:0]    note;

  modport source (output valid, output mode, output note, input ready);
  modport sink   (input valid, input mode, input note, output ready);
endinterface

interface mpva_res_if;
  logic                          valid;
  logic                          ready;
  mpva_pkg::action_e             action;
  logic [mpva_pkg::VoiceW-1:0]   voice;
  logic [mpva_pkg::WordW-1:0]    frequency_word;
  logic [mpva_pkg::ClassW-1:0]   pitch_class;
  logic [mpva_pkg::OctW-1:0]     octave;
  logic                          out_of_voices;

  modport source (output valid, output action, output voice, output frequency_word,
                  output pitch_class, output octave, output out_of_voices, input ready);
  modport sink   (input valid, input action, input voice, input frequency_word,
                  input pitch_class, input octave, input out_of_voices, output ready);
endinterface

>>> src/midi_polyphonic_voice_allocator.sv
// ----------------------------------------------------------------------------
// midi_polyphonic_voice_allocator
// Note-on/note-off events in on evt_i, one allocation result per event out
// on res_o; both are valid/ready channels, an item moves when both are high.
// A note-on claims the lowest free voice and reports its oscillator word,
// pitch class and octave; a note-off frees the lowest busy voice holding
// the note. Refusals (no voice free, pitch too high) still give one result.
// An accepted item passes the input register, then the result register,
// and a held result can keep it waiting in the input register.
// Throughput: one item per cycle while results are taken, set by the single
// pass of allocation and table lookup between the two registers; the voice
// state is updated as the result is registered, so the next item sees it.
// Reset: all voices free, out-of-voices flag clear, both stages empty.
// Stall: a held result keeps the result register; the input register still
// takes one more item, then evt_i.ready drops until res_o.ready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midi_polyphonic_voice_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpva_evt_if.sink          evt_i,
  mpva_res_if.source        res_o
);

  // Input stage
  logic                       in_valid_q;
  mpva_pkg::mode_e            in_mode_q;
  logic [mpva_pkg::NoteW-1:0] in_note_q;

  // Result stage
  logic                       out_valid_q;
  mpva_pkg::result_t          out_res_q;

  logic                       advance;
  mpva_pkg::pitch_t           pitch;
  mpva_pkg::alloc_t           alloc;
  mpva_pkg::result_t          res_d;

  // Move the input stage on whenever the result register is free or draining
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      in_mode_q <= evt_i.mode;
      in_note_q <= evt_i.note;
    end
  end

  mpva_pitch u_pitch (
    .note_i  (in_note_q),
    .pitch_o (pitch)
  );

  // State changes only when the item really moves into the result register
  mpva_voices u_voices (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (advance),
    .mode_i     (in_mode_q),
    .note_n_i   (pitch.note_n),
    .too_high_i (pitch.too_high),
    .alloc_o    (alloc)
  );

  always_comb begin
    res_d.action         = alloc.action;
    res_d.voice          = mpva_pkg::VoiceW'(alloc.voice);
    res_d.frequency_word = (alloc.action == mpva_pkg::ActStarted) ? pitch.word : '0;
    res_d.pitch_class    = pitch.pitch_class;
    res_d.octave         = pitch.octave;
    res_d.out_of_voices  = alloc.out_of_voices;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.action         = out_res_q.action;
  assign res_o.voice          = out_res_q.voice;
  assign res_o.frequency_word = out_res_q.frequency_word;
  assign res_o.pitch_class    = out_res_q.pitch_class;
  assign res_o.octave         = out_res_q.octave;
  assign res_o.out_of_voices  = out_res_q.out_of_voices;

  `ASSERT_PROP(a_stalled_input_holds, clk_i, rst_ni,
    in_valid_q && !advance |=> in_valid_q && $stable(in_note_q) && $stable(in_mode_q))

  `ASSERT_NEVER(a_word_only_when_started, clk_i, rst_ni,
    out_valid_q && out_res_q.action != mpva_pkg::ActStarted &&
      out_res_q.frequency_word != '0)

  `ASSERT_NEVER(a_voice_only_when_used, clk_i, rst_ni,
    out_valid_q && out_res_q.action != mpva_pkg::ActStarted &&
      out_res_q.action != mpva_pkg::ActStopped && out_res_q.voice != '0)

endmodule

>>> src/mpva_pitch.sv
// ----------------------------------------------------------------------------
// mpva_pitch
// Offset note, pitch class, octave and oscillator word with range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpva_pitch (
  input  logic [mpva_pkg::NoteW-1:0] note_i,
  output mpva_pkg::pitch_t           pitch_o
);

  logic [mpva_pkg::OffNoteW-1:0]  n;
  logic [mpva_pkg::ProdW-1:0]     prod;
  logic [mpva_pkg::OctW-1:0]      q;
  logic [mpva_pkg::OffNoteW-1:0]  q12;
  logic [mpva_pkg::ClassW-1:0]    r;
  logic [mpva_pkg::OctW-1:0]      sh;
  logic [mpva_pkg::BaseW-1:0]     base;
  logic [mpva_pkg::BaseW-1:0]     shifted;

  always_comb begin
    n    = mpva_pkg::OffNoteW'(note_i) + mpva_pkg::OffNoteW'(mpva_pkg::NoteOffset);
    // reciprocal multiply for n / 12
    prod = mpva_pkg::ProdW'(n) * mpva_pkg::ProdW'(mpva_pkg::DivTwelveMul);
    q    = prod[mpva_pkg::DivTwelveShift +: mpva_pkg::OctW];
    q12  = mpva_pkg::OffNoteW'(q) * mpva_pkg::OffNoteW'(mpva_pkg::Semitones);
    r    = mpva_pkg::ClassW'(n - q12);

    base    = mpva_pkg::FreqBase[r];
    sh      = mpva_pkg::OctW'(mpva_pkg::TopOctave) - q;
    shifted = base >> sh;

    pitch_o.note_n      = n;
    pitch_o.pitch_class = r;
    pitch_o.octave      = q;
    pitch_o.word        = shifted[mpva_pkg::WordW-1:0];
    pitch_o.too_high    = |shifted[mpva_pkg::BaseW-1:mpva_pkg::WordW];
  end

endmodule

>>> src/mpva_voices.sv
// ----------------------------------------------------------------------------
// mpva_voices
// Voice state, lowest-free allocation and note-off release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpva_voices (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          commit_i,
  input  mpva_pkg::mode_e               mode_i,
  input  logic [mpva_pkg::OffNoteW-1:0] note_n_i,
  input  logic                          too_high_i,
  output mpva_pkg::alloc_t              alloc_o
);

  logic [mpva_pkg::Voices-1:0]   busy_q, busy_d;
  logic [mpva_pkg::OffNoteW-1:0] note_q [mpva_pkg::Voices];
  logic                          exhausted_q, exhausted_d;

  logic                           free_hit, match_hit;
  logic [mpva_pkg::VoiceIdxW-1:0] free_idx, match_idx;
  logic                           ev_exhausted;
  logic                           claim;

  // Priority search, lowest index wins (last assignment)
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = mpva_pkg::Voices - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_hit = 1'b1;
        free_idx = mpva_pkg::VoiceIdxW'(i);
      end
      if (busy_q[i] && (note_q[i] == note_n_i)) begin
        match_hit = 1'b1;
        match_idx = mpva_pkg::VoiceIdxW'(i);
      end
    end
  end

  always_comb begin
    alloc_o.action = mpva_pkg::ActNoMatch;
    alloc_o.voice  = '0;
    ev_exhausted   = exhausted_q;
    claim          = 1'b0;
    busy_d         = busy_q;

    if (mode_i == mpva_pkg::ModeNoteOn) begin
      if (!free_hit) begin
        ev_exhausted   = 1'b1;
        alloc_o.action = mpva_pkg::ActNoVoice;
      end else if (too_high_i) begin
        alloc_o.action = mpva_pkg::ActTooHigh;
      end else begin
        alloc_o.action = mpva_pkg::ActStarted;
        alloc_o.voice  = free_idx;
        claim          = commit_i;
        if (commit_i) begin
          busy_d[free_idx] = 1'b1;
        end
      end
    end else begin
      ev_exhausted = 1'b0;
      if (match_hit) begin
        alloc_o.action = mpva_pkg::ActStopped;
        alloc_o.voice  = match_idx;
        if (commit_i) begin
          busy_d[match_idx] = 1'b0;
        end
      end
    end

    alloc_o.out_of_voices = ev_exhausted;
    exhausted_d           = commit_i ? ev_exhausted : exhausted_q;
  end

  // Busy flags, held notes and the out-of-voices flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      note_q      <= '{default: '0};
      exhausted_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      exhausted_q <= exhausted_d;
      if (claim) begin
        note_q[free_idx] <= note_n_i;
      end
    end
  end

  `ASSERT_PROP(a_start_claims_one, clk_i, rst_ni,
    commit_i && alloc_o.action == mpva_pkg::ActStarted |=>
      $countones(busy_q) == $past($countones(busy_q)) + 1)

  `ASSERT_PROP(a_stop_frees_one, clk_i, rst_ni,
    commit_i && alloc_o.action == mpva_pkg::ActStopped |=>
      $countones(busy_q) + 1 == $past($countones(busy_q)))

  `ASSERT_PROP(a_refusal_when_full, clk_i, rst_ni,
    alloc_o.action == mpva_pkg::ActNoVoice |-> (&busy_q))

  `ASSERT_PROP(a_note_off_clears_flag, clk_i, rst_ni,
    commit_i && mode_i == mpva_pkg::ModeNoteOff |=> !exhausted_q)

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives note events into the voice allocator, predicts every allocation
// result with a local model of the voice table and checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // --------------------------------------------------------------------------
  // Voice table predictor and queue of expected allocation results
  // --------------------------------------------------------------------------
  class VoiceScoreboard;
    // 2^(r/12) in unsigned Q32, one per semitone above A
    logic [63:0] semitone_ratio [12] = '{
      64'd4294967296, 64'd4550359342, 64'd4820937788, 64'd5107605667,
      64'd5411319705, 64'd5733093519, 64'd6074001000, 64'd6435179895,
      64'd6817835604, 64'd7223245206, 64'd7652761717, 64'd8107818609
    };
    bit                 busy [3];
    bit [7:0]           held_note [3];
    bit                 exhausted;
    mpva_pkg::result_t  expected_results [$];
    int                 errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        busy[i] = 1'b0;
        held_note[i] = 8'd0;
      end
      exhausted = 1'b0;
      errors = 0;
    endfunction

    // floor(440 * 2^(r/12) * 2^32 / (bus clock << (13 - octave)))
    function logic [63:0] osc_word(bit [7:0] n);
      logic [63:0] num;
      logic [63:0] den;
      int          oct;
      oct = n / 12;
      if (oct > 13) oct = 13;
      num = 64'd440 * semitone_ratio[n % 12];
      den = 64'd1022727 << (13 - oct);
      return num / den;
    endfunction

    // Accepted event: advance the voice table and queue the result it gives
    function void note_event(mpva_pkg::mode_e mode, logic [6:0] note);
      mpva_pkg::result_t res;
      bit [7:0]          n;
      int                slot;
      logic [63:0]       w;
      n = {1'b0, note} + 8'd3;
      slot = -1;
      res.action = mpva_pkg::ActNoMatch;
      res.voice = '0;
      res.frequency_word = '0;
      if (mode == mpva_pkg::ModeNoteOn) begin
        for (int i = 0; i < 3; i++)
          if (slot < 0 && !busy[i]) slot = i;
        if (slot < 0) begin
          exhausted = 1'b1;
          res.action = mpva_pkg::ActNoVoice;
        end else begin
          w = osc_word(n);
          if (w > 64'hffff) begin
            res.action = mpva_pkg::ActTooHigh;
          end else begin
            busy[slot] = 1'b1;
            held_note[slot] = n;
            res.action = mpva_pkg::ActStarted;
            res.voice = slot[1:0];
            res.frequency_word = w[15:0];
          end
        end
      end else begin
        exhausted = 1'b0;
        for (int i = 0; i < 3; i++)
          if (slot < 0 && busy[i] && held_note[i] == n) slot = i;
        if (slot >= 0) begin
          busy[slot] = 1'b0;
          res.action = mpva_pkg::ActStopped;
          res.voice = slot[1:0];
        end
      end
      res.pitch_class = 4'(n % 12);
      res.octave = 4'(n / 12);
      res.out_of_voices = exhausted;
      expected_results.push_back(res);
    endfunction

    function void check_result(mpva_pkg::result_t got);
      mpva_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no event outstanding: action %0d", got.action);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        errors++;
      end
      if (got.voice !== want.voice) begin
        $error("voice: expected %0d, got %0d", want.voice, got.voice);
        errors++;
      end
      if (got.frequency_word !== want.frequency_word) begin
        $error("frequency_word: expected %0d, got %0d", want.frequency_word,
               got.frequency_word);
        errors++;
      end
      if (got.pitch_class !== want.pitch_class) begin
        $error("pitch_class: expected %0d, got %0d", want.pitch_class, got.pitch_class);
        errors++;
      end
      if (got.octave !== want.octave) begin
        $error("octave: expected %0d, got %0d", want.octave, got.octave);
        errors++;
      end
      if (got.out_of_voices !== want.out_of_voices) begin
        $error("out_of_voices: expected %0d, got %0d", want.out_of_voices,
               got.out_of_voices);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  mpva_evt_if evt_ch ();
  mpva_res_if res_ch ();

  midi_polyphonic_voice_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_ch),
    .res_o  (res_ch)
  );

  VoiceScoreboard sb = new();

  // Idle rates in percent; changed between phases
  int send_idle_pct = 35;
  int recv_idle_pct = 52;

  // Inputs known from time zero
  initial begin
    evt_ch.valid = 1'b0;
    evt_ch.mode  = mpva_pkg::ModeNoteOff;
    evt_ch.note  = '0;
    res_ch.ready = 1'b0;
  end

  // Receiver: one fresh ready decision per falling edge
  always @(negedge clk_i)
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  // Monitor: results first (they belong to older items), then new events
  always @(posedge clk_i) begin
    mpva_pkg::result_t got;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got.action         = res_ch.action;
        got.voice          = res_ch.voice;
        got.frequency_word = res_ch.frequency_word;
        got.pitch_class    = res_ch.pitch_class;
        got.octave         = res_ch.octave;
        got.out_of_voices  = res_ch.out_of_voices;
        sb.check_result(got);
      end
      if (evt_ch.valid && evt_ch.ready)
        sb.note_event(evt_ch.mode, evt_ch.note);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Each is entered and left at a falling edge. Valid is never
  // lowered after an item unless the next call idles, so a back-to-back item
  // only sees one assignment to valid in that step.
  // --------------------------------------------------------------------------
  task automatic send_event(mpva_pkg::mode_e mode, logic [6:0] note);
    while ($urandom_range(99) < send_idle_pct) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.mode  <= mode;
    evt_ch.note  <= note;
    do @(posedge clk_i); while (!evt_ch.ready);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has been taken
  task automatic drain_results();
    evt_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
  endtask

  // Mostly playable runs on a small note pool so note-offs find their voice;
  // the rest is noise across the whole event space
  task automatic send_random(int count);
    logic [6:0] pool [4];
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        for (int k = 0; k < 4; k++)
          pool[k] = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 90))
                                              : 7'($urandom_range(95));
      if ($urandom_range(99) < 15)
        send_event(mpva_pkg::mode_e'($urandom_range(1)), 7'($urandom_range(127)));
      else
        send_event(($urandom_range(99) < 55) ? mpva_pkg::ModeNoteOn
                                             : mpva_pkg::ModeNoteOff,
                   pool[$urandom_range(3)]);
      // one hold-off part way through a phase
      if (i == count / 2) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: range ends, word boundary, full table, refusals, duplicates
    send_event(mpva_pkg::ModeNoteOn,  7'd0);     // lowest note, voice 0
    send_event(mpva_pkg::ModeNoteOn,  7'd95);    // highest note whose word fits, voice 1
    send_event(mpva_pkg::ModeNoteOn,  7'd96);    // first note whose word overflows
    send_event(mpva_pkg::ModeNoteOn,  7'd127);   // top note, also too high
    send_event(mpva_pkg::ModeNoteOn,  7'd60);    // voice 2, table now full
    send_event(mpva_pkg::ModeNoteOn,  7'd60);    // no free voice, flag set
    send_event(mpva_pkg::ModeNoteOn,  7'd127);   // full table wins over pitch check
    send_event(mpva_pkg::ModeNoteOff, 7'd61);    // unmatched note-off clears the flag
    send_event(mpva_pkg::ModeNoteOff, 7'd95);    // frees voice 1
    send_event(mpva_pkg::ModeNoteOn,  7'd60);    // duplicate note takes voice 1
    send_event(mpva_pkg::ModeNoteOff, 7'd60);    // lowest holder first: voice 1
    send_event(mpva_pkg::ModeNoteOff, 7'd60);    // then voice 2
    send_event(mpva_pkg::ModeNoteOff, 7'd60);    // nothing left holding it
    send_event(mpva_pkg::ModeNoteOff, 7'd0);     // frees voice 0
    send_event(mpva_pkg::ModeNoteOff, 7'd127);   // unmatched, top note, octave 10
    send_event(mpva_pkg::ModeNoteOn,  7'd127);   // too high with every voice free
    send_event(mpva_pkg::ModeNoteOn,  7'd85);
    send_event(mpva_pkg::ModeNoteOn,  7'd42);
    send_event(mpva_pkg::ModeNoteOn,  7'd21);
    send_event(mpva_pkg::ModeNoteOn,  7'd106);   // full again, flag set
    send_event(mpva_pkg::ModeNoteOff, 7'd42);    // frees middle voice, flag cleared
    send_event(mpva_pkg::ModeNoteOn,  7'd9);     // refills the middle voice
    drain_results();

    // Random phases with differing idle patterns
    send_random(630);
    drain_results();
    send_idle_pct = 52;
    recv_idle_pct = 35;
    send_random(630);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(640);
    drain_results();

    // Allow for the two-stage pipeline before judging leftovers
    repeat (10) @(negedge clk_i);
    if (sb.outstanding() != 0)
      $error("%0d expected results never arrived", sb.outstanding());

    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
